// File: sv/sensor_running_average_monitor_core_assert.svh
// assertion macros shared by the running average monitor
// each macro checks on the rising clock edge and is muted while reset is low
`ifndef SENSOR_RUNNING_AVERAGE_MONITOR_CORE_ASSERT_SVH
`define SENSOR_RUNNING_AVERAGE_MONITOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRAMON_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SRAMON_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SRAMON_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRAMON_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/sramon_pkg.sv
`timescale 1ns / 1ps

package sramon_pkg;

    localparam int unsigned DATA_W   = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b1;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_MEASURE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_AVG_ZERO = 3'd3,
        ST_NORMAL   = 3'd4,
        ST_TOO_COLD = 3'd5,
        ST_TOO_HOT  = 3'd6
    } t_status;

    typedef struct packed {
        logic                     operation;
        logic [DATA_W-1:0]        node_id;
        logic [DATA_W-1:0]        room_id;
        logic signed [DATA_W-1:0] temperature;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [DATA_W-1:0]        reported_sensor;
        logic [DATA_W-1:0]        reported_room;
        logic signed [DATA_W-1:0] average;
    } t_out_word;

    // decoded command passed from the front end to the execution side
    typedef struct packed {
        t_op                      op;
        logic [DATA_W-1:0]        node_id;
        logic [DATA_W-1:0]        room_id;
        logic signed [DATA_W-1:0] temperature;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_temp;
        logic signed [DATA_W-1:0] max_temp;
    } t_thresh;

endpackage

// File: sv/sramon_front.sv
`timescale 1ns / 1ps

module sramon_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sramon_pkg::t_in_word  i_word,
    output logic                  o_push,
    output sramon_pkg::t_cmd      o_cmd,
    input  logic                  i_full
);
    import sramon_pkg::*;

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // decode the operation and drop the field the operation ignores
    always_comb begin
        n_cmd.op          = t_op'(i_word.operation);
        n_cmd.node_id     = i_word.node_id;
        n_cmd.room_id     = (n_cmd.op == OP_LOAD) ? i_word.room_id : '0;
        n_cmd.temperature = (n_cmd.op == OP_MEASURE) ? i_word.temperature : '0;
    end

    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_vld <= 1'b1;
            end else if (o_push) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: sv/sramon_cmd_fifo.sv
`timescale 1ns / 1ps

module sramon_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sramon_pkg::t_cmd  i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output sramon_pkg::t_cmd  o_head,
    output logic              o_empty
);
    import sramon_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    t_cmd             r_slot [DEPTH];

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// File: sv/sramon_back.sv
`timescale 1ns / 1ps
`include "sensor_running_average_monitor_core_assert.svh"

module sramon_back #(
    parameter int unsigned MAX_SENSORS = 16,
    parameter int unsigned AVG_LEN     = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sramon_pkg::t_cmd      i_cmd,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  sramon_pkg::t_thresh   i_thr,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sramon_pkg::t_out_word o_out_word
);
    import sramon_pkg::*;

    localparam int unsigned IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int unsigned CNT_W   = $clog2(MAX_SENSORS + 1);
    localparam int unsigned HIST_W  = AVG_LEN * DATA_W;
    localparam int unsigned LOG_LEN = $clog2(AVG_LEN);
    localparam int unsigned SUM_W   = DATA_W + LOG_LEN;
    // reciprocal of the history length, exact for every sum magnitude below 2**SUM_W
    localparam int unsigned DIV_SH  = SUM_W + LOG_LEN;
    localparam int unsigned RECIP_W = SUM_W + 1;
    localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + AVG_LEN - 1) / AVG_LEN;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;

    typedef struct packed {
        logic [DATA_W-1:0]       id;
        logic [DATA_W-1:0]       room;
        logic signed [SUM_W-1:0] sum;
        logic [HIST_W-1:0]       hist;
    } t_row;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_ABS,
        S_MUL,
        S_FIN
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_idx;
    logic                     r_cmp_vld;
    logic [IDX_W-1:0]         r_cmp_idx;
    t_row                     r_row_q;
    logic signed [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0]        r_room;
    logic [SUM_W-1:0]         r_mag;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_out_vld;
    t_out_word                r_out;
    t_row                     r_tbl [MAX_SENSORS];

    logic                     pop;
    logic                     scan_issue;
    logic [IDX_W-1:0]         rd_addr;
    logic                     hit;
    logic                     miss;
    logic                     tbl_full;
    logic                     load_ok;
    logic [HIST_W+DATA_W-1:0] shift_cat;
    logic signed [DATA_W-1:0] oldest;
    logic signed [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]         n_mag;
    logic [DATA_W-1:0]        quot;
    logic signed [DATA_W-1:0] n_avg;
    t_status                  n_class;
    logic                     tbl_we;
    logic [IDX_W-1:0]         tbl_waddr;
    t_row                     tbl_wdata;

    assign pop        = (r_state == S_IDLE) && !i_empty && (!r_out_vld || i_out_ready);
    assign o_pop      = pop;
    assign tbl_full   = (r_count == CNT_W'(MAX_SENSORS));
    assign load_ok    = (r_state == S_EXEC) && (r_cmd.op == OP_LOAD) && !tbl_full;

    // one table row per cycle during the id search
    assign scan_issue = (r_idx < r_count);
    assign rd_addr    = scan_issue ? r_idx[IDX_W-1:0] : '0;
    assign hit        = (r_state == S_SCAN) && r_cmp_vld && (r_row_q.id == r_cmd.node_id);
    assign miss       = (r_state == S_SCAN) && !r_cmp_vld && !scan_issue;

    // history shift with a running sum: drop the oldest sample, add the new one
    assign shift_cat  = {r_row_q.hist, r_cmd.temperature};
    assign oldest     = r_row_q.hist[HIST_W-1 -: DATA_W];
    assign n_sum      = r_row_q.sum - SUM_W'(oldest) + SUM_W'(r_cmd.temperature);

    assign n_mag      = r_sum[SUM_W-1] ? SUM_W'(~r_sum + 1'b1) : r_sum;
    assign quot       = r_prod[DIV_SH +: DATA_W];
    assign n_avg      = r_neg ? DATA_W'(~quot + 1'b1) : quot;

    always_comb begin
        priority if (n_avg == '0) begin
            n_class = ST_AVG_ZERO;
        end else if (n_avg < i_thr.min_temp) begin
            n_class = ST_TOO_COLD;
        end else if (n_avg > i_thr.max_temp) begin
            n_class = ST_TOO_HOT;
        end else begin
            n_class = ST_NORMAL;
        end
    end

    always_comb begin
        tbl_we    = load_ok || hit;
        tbl_waddr = hit ? r_cmp_idx : r_count[IDX_W-1:0];
        if (hit) begin
            tbl_wdata.id   = r_row_q.id;
            tbl_wdata.room = r_row_q.room;
            tbl_wdata.sum  = n_sum;
            tbl_wdata.hist = shift_cat[HIST_W-1:0];
        end else begin
            tbl_wdata.id   = r_cmd.node_id;
            tbl_wdata.room = r_cmd.room_id;
            tbl_wdata.sum  = '0;
            tbl_wdata.hist = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        r_row_q <= r_tbl[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd.op == OP_LOAD) begin
                        r_out_vld                 <= 1'b1;
                        r_out.reported_sensor     <= r_cmd.node_id;
                        r_out.average             <= '0;
                        if (tbl_full) begin
                            r_out.status        <= ST_FULL;
                            r_out.reported_room <= '0;
                        end else begin
                            r_out.status        <= ST_LOADED;
                            r_out.reported_room <= r_cmd.room_id;
                            r_count             <= r_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= scan_issue && !hit;
                    r_cmp_idx <= rd_addr;
                    if (scan_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (hit) begin
                        r_sum   <= n_sum;
                        r_room  <= r_row_q.room;
                        r_state <= S_ABS;
                    end else if (miss) begin
                        r_out_vld             <= 1'b1;
                        r_out.status          <= ST_UNKNOWN;
                        r_out.reported_sensor <= r_cmd.node_id;
                        r_out.reported_room   <= '0;
                        r_out.average         <= '0;
                        r_state               <= S_IDLE;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_mag   <= n_mag;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_mag) * PROD_W'(RECIP_C);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_out_vld             <= 1'b1;
                    r_out.status          <= n_class;
                    r_out.reported_sensor <= r_cmd.node_id;
                    r_out.reported_room   <= r_room;
                    r_out.average         <= n_avg;
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    `SRAMON_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_SENSORS), "entry count past table size")
    `SRAMON_ASSERT_IMP(a_cmp_in_scan, i_clk, i_rst_n, r_cmp_vld, r_state == S_SCAN, "compare pending outside search")
    `SRAMON_ASSERT_IMP(a_scan_idx, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= r_count, "search index past entry count")
    `SRAMON_ASSERT_IMP(a_out_free, i_clk, i_rst_n, r_state == S_EXEC, !r_out_vld, "command started with result slot busy")

endmodule

// File: sv/sensor_running_average_monitor_core.sv
`timescale 1ns / 1ps
// flow: a word passes the front register and the command queue; the sequencer pops it in S_IDLE
//   when the result slot is free or being read; a load ends in S_EXEC, a measurement runs S_EXEC,
//   S_SCAN, S_ABS, S_MUL, S_FIN, and an unknown id ends in S_SCAN once every entry is read; search
//   time grows with the matched entry index or the entry count, set by the one-row-a-cycle search
// reset: synchronous, active low; clears thresholds, entry count, queue and handshakes
//   table rows are not swept, a load clears the history of the row it appends

module sensor_running_average_monitor_core #(
    parameter int unsigned MAX_SENSORS = 16,
    parameter int unsigned AVG_LEN     = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input words
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sramon_pkg::t_in_word           i_in_word,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sramon_pkg::t_out_word          o_out_word,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [sramon_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sramon_pkg::DATA_W-1:0]  i_cfg_wdata
);
    import sramon_pkg::*;

    // thresholds, to be written only while the block is idle; the block itself does not enforce it
    logic signed [DATA_W-1:0] r_min_temp;
    logic signed [DATA_W-1:0] r_max_temp;
    t_thresh                  thr;

    // front end to queue
    logic                     front_push;
    t_cmd                     front_cmd;
    logic                     fifo_full;

    // queue to execution side
    t_cmd                     fifo_head;
    logic                     fifo_empty;
    logic                     back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp <= '0;
            r_max_temp <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_TEMP: r_min_temp <= i_cfg_wdata;
                CFG_MAX_TEMP: r_max_temp <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign thr.min_temp = r_min_temp;
    assign thr.max_temp = r_max_temp;

    // front end: registers the word and decodes the operation
    sramon_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_push  (front_push),
        .o_cmd   (front_cmd),
        .i_full  (fifo_full)
    );

    // two-deep command queue so the front end keeps taking words during a long search
    sramon_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (back_pop),
        .o_head  (fifo_head),
        .o_empty (fifo_empty)
    );

    // execution side: table memory, id search, history update, average and classification
    sramon_back #(
        .MAX_SENSORS (MAX_SENSORS),
        .AVG_LEN     (AVG_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (fifo_head),
        .i_empty     (fifo_empty),
        .o_pop       (back_pop),
        .i_thr       (thr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
